@@ rtl/brf_pkg.sv @@
// Shared types and constants for the byte ring FIFO with search.
// Used by brf_ctrl, brf_dp and byte_ring_fifo_with_search; depends on nothing.
`timescale 1ns / 1ps

package brf_pkg;

	localparam int DEPTH_DEF       = 1024;
	localparam int PATTERN_MAX_DEF = 8;

	localparam int CMD_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int PAT_W    = 64;
	localparam int LEN_W    = 4;
	localparam int STATUS_W = 2;
	localparam int OFFS_W   = 10;
	localparam int FILL_W   = 10;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH      = 2'd0,
		CMD_POP       = 2'd1,
		CMD_FIND_BYTE = 2'd2,
		CMD_FIND_PAT  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_WAIT,
		S_SCAN
	} state_t;

	typedef struct packed {
		logic    push;
		logic    pop;
		logic    scan_start;
		logic    scan;
		logic    load_out;
		status_t status;
		logic    use_rdata;
		logic    use_offset;
	} ctl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic reject;
		logic hit;
		logic last;
	} dp_stat_t;

endpackage

@@ rtl/brf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module brf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/brf_ctrl.sv @@
// Controller state machine: request handshake, command sequencing, result valid.
// Depends on brf_pkg.
`timescale 1ns / 1ps

module brf_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [brf_pkg::CMD_W-1:0]    command,
	output logic                         out_valid,
	input  logic                         out_stall,
	input  brf_pkg::dp_stat_t            stat,
	output brf_pkg::ctl_cmd_t            ctl
);

	brf_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_busy;

	assign out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brf_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		ctl      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			brf_pkg::S_IDLE: begin
				in_stall = out_busy;
				if (in_valid && !out_busy) begin
					case (brf_pkg::cmd_t'(command))
						brf_pkg::CMD_PUSH: begin
							ctl.load_out = 1'b1;
							if (stat.full) begin
								ctl.status = brf_pkg::ST_FULL;
							end else begin
								ctl.push   = 1'b1;
								ctl.status = brf_pkg::ST_OK;
							end
						end
						brf_pkg::CMD_POP: begin
							if (stat.empty) begin
								ctl.load_out = 1'b1;
								ctl.status   = brf_pkg::ST_EMPTY;
							end else begin
								ctl.pop = 1'b1;
								state_d = brf_pkg::S_POP_WAIT;
							end
						end
						brf_pkg::CMD_FIND_BYTE, brf_pkg::CMD_FIND_PAT: begin
							if (stat.reject) begin
								ctl.load_out = 1'b1;
								ctl.status   = brf_pkg::ST_NOT_FOUND;
							end else begin
								ctl.scan_start = 1'b1;
								state_d        = brf_pkg::S_SCAN;
							end
						end
						default: begin
							state_d = brf_pkg::S_IDLE;
						end
					endcase
				end
			end
			brf_pkg::S_POP_WAIT: begin
				ctl.load_out  = 1'b1;
				ctl.status    = brf_pkg::ST_OK;
				ctl.use_rdata = 1'b1;
				state_d       = brf_pkg::S_IDLE;
			end
			brf_pkg::S_SCAN: begin
				ctl.scan = 1'b1;
				if (stat.hit) begin
					ctl.load_out   = 1'b1;
					ctl.status     = brf_pkg::ST_OK;
					ctl.use_offset = 1'b1;
					state_d        = brf_pkg::S_IDLE;
				end else if (stat.last) begin
					ctl.load_out = 1'b1;
					ctl.status   = brf_pkg::ST_NOT_FOUND;
					state_d      = brf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = brf_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/brf_dp.sv @@
// Datapath: ring pointers, fill count, byte store, scan pipeline and result register.
// Depends on brf_pkg and brf_ram.
`timescale 1ns / 1ps

module brf_dp #(
	parameter int DEPTH       = brf_pkg::DEPTH_DEF,
	parameter int PATTERN_MAX = brf_pkg::PATTERN_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [brf_pkg::CMD_W-1:0]      command,
	input  logic [brf_pkg::BYTE_W-1:0]     data_byte,
	input  logic [brf_pkg::PAT_W-1:0]      pattern_bytes,
	input  logic [brf_pkg::LEN_W-1:0]      pattern_len,
	input  brf_pkg::ctl_cmd_t              ctl,
	output brf_pkg::dp_stat_t              stat,
	output logic [brf_pkg::STATUS_W-1:0]   status,
	output logic [brf_pkg::BYTE_W-1:0]     read_byte,
	output logic [brf_pkg::OFFS_W-1:0]     found_offset,
	output logic [brf_pkg::FILL_W-1:0]     fill_level
);

	localparam int AW  = $clog2(DEPTH);
	localparam int LW  = brf_pkg::LEN_W;
	localparam int BW  = brf_pkg::BYTE_W;
	localparam int PIW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int MW  = (AW + 1 > LW) ? AW + 1 : LW;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);

	logic [AW-1:0] rd_ptr_q, wr_ptr_q, fill_q, fill_d;
	logic [AW-1:0] rd_inc, wr_inc, issue_cnt_q, scan_addr;
	logic [AW:0]   scan_sum;
	logic [AW-1:0] cnt_s1, cnt_s2;
	logic          valid_s1, valid_s2;
	logic          issue;
	logic [BW-1:0] win_q [PATTERN_MAX];
	logic [BW-1:0] pat_q [PATTERN_MAX];
	logic [LW-1:0] len_q, eff_len;
	logic          match, count_ok;
	logic [MW-1:0] cnt_plus;
	logic [MW-1:0] offset;

	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [BW-1:0] ram_rdata;

	logic [brf_pkg::STATUS_W-1:0] status_q;
	logic [BW-1:0]                read_byte_q;
	logic [brf_pkg::OFFS_W-1:0]   found_offset_q;
	logic [brf_pkg::FILL_W-1:0]   fill_level_q;

	assign rd_inc = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + AW'(1);
	assign wr_inc = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + AW'(1);

	assign scan_sum  = {1'b0, rd_ptr_q} + {1'b0, issue_cnt_q};
	assign scan_addr = (scan_sum >= DEPTH_W) ? AW'(scan_sum - DEPTH_W) : scan_sum[AW-1:0];
	assign issue     = ctl.scan && (issue_cnt_q != fill_q);

	assign eff_len = (command == brf_pkg::CMD_FIND_BYTE) ? LW'(1) : pattern_len;

	always_comb begin
		fill_d = fill_q;
		if (ctl.push) begin
			fill_d = fill_q + AW'(1);
		end else if (ctl.pop) begin
			fill_d = fill_q - AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			fill_q      <= '0;
			issue_cnt_q <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (ctl.push) begin
				wr_ptr_q <= wr_inc;
			end
			if (ctl.pop) begin
				if (fill_q == AW'(1)) begin
					rd_ptr_q <= '0;
					wr_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_inc;
				end
			end
			if (ctl.scan_start) begin
				issue_cnt_q <= '0;
			end else if (issue) begin
				issue_cnt_q <= issue_cnt_q + AW'(1);
			end
			valid_s1 <= issue;
			valid_s2 <= ctl.scan && valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		cnt_s1 <= issue_cnt_q;
		if (valid_s1) begin
			cnt_s2   <= cnt_s1;
			win_q[0] <= ram_rdata;
			for (int m = 1; m < PATTERN_MAX; m++) begin
				win_q[m] <= win_q[m-1];
			end
		end
		if (ctl.scan_start) begin
			len_q <= eff_len;
			for (int j = 0; j < PATTERN_MAX; j++) begin
				pat_q[j] <= pattern_bytes[BW*j +: BW];
			end
			if (command == brf_pkg::CMD_FIND_BYTE) begin
				pat_q[0] <= data_byte;
			end
		end
	end

	assign ram_re    = ctl.pop || issue;
	assign ram_raddr = ctl.pop ? rd_ptr_q : scan_addr;

	brf_ram #(
		.WIDTH (BW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ctl.push),
		.waddr (wr_ptr_q),
		.wdata (data_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		logic [LW-1:0] pidx;
		match = 1'b1;
		pidx  = '0;
		for (int m = 0; m < PATTERN_MAX; m++) begin
			if (LW'(m) < len_q) begin
				pidx = len_q - LW'(m + 1);
				if (win_q[m] != pat_q[pidx[PIW-1:0]]) begin
					match = 1'b0;
				end
			end
		end
	end

	assign cnt_plus = MW'(cnt_s2) + MW'(1);
	assign count_ok = cnt_plus >= MW'(len_q);
	assign offset   = cnt_plus - MW'(len_q);

	always_comb begin
		stat        = '0;
		stat.full   = (fill_q == LAST_SLOT);
		stat.empty  = (fill_q == '0);
		stat.reject = (eff_len == '0) || (MW'(eff_len) > MW'(PATTERN_MAX))
			|| (MW'(eff_len) > MW'(fill_q));
		stat.hit    = valid_s2 && match && count_ok;
		stat.last   = valid_s2 && (cnt_s2 == fill_q - AW'(1));
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			status_q       <= ctl.status;
			read_byte_q    <= ctl.use_rdata ? ram_rdata : '0;
			found_offset_q <= ctl.use_offset ? brf_pkg::OFFS_W'(offset) : '0;
			fill_level_q   <= brf_pkg::FILL_W'(fill_d);
		end
	end

	assign status       = status_q;
	assign read_byte    = read_byte_q;
	assign found_offset = found_offset_q;
	assign fill_level   = fill_level_q;

endmodule

@@ rtl/byte_ring_fifo_with_search.sv @@
// Top level of the byte ring FIFO with search: controller plus datapath.
// Depends on brf_pkg, brf_ctrl, brf_dp (and brf_ram below it).
`timescale 1ns / 1ps

// Usage:
// One request on the input channel (in_valid/in_stall) carries a command:
// push, pop, find byte or find pattern. Each request yields exactly one
// result on the output channel (out_valid/out_stall), in request order.
// The ring holds at most DEPTH-1 bytes; a pop that empties it rewinds
// both pointers to slot zero.
// Request sequencing, set by the single read port of the byte store:
//   push: result registered at the accepting edge
//   pop: one store read, then the result is registered from S_POP_WAIT
//   find: one byte read per cycle until a hit or the last held byte, two-stage
//   compare window; a rejected find (empty, bad length) is registered like a push.
// A result waits in the output register while out_stall is high; a new
// request is accepted once that register is free or being taken.
// Reset clears both pointers, the fill count and all valid flags; the byte
// store has no reset and needs no clearing pass.
module byte_ring_fifo_with_search #(
	parameter int DEPTH       = brf_pkg::DEPTH_DEF,
	parameter int PATTERN_MAX = brf_pkg::PATTERN_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [brf_pkg::CMD_W-1:0]      command,
	input  logic [brf_pkg::BYTE_W-1:0]     data_byte,
	input  logic [brf_pkg::PAT_W-1:0]      pattern_bytes,
	input  logic [brf_pkg::LEN_W-1:0]      pattern_len,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [brf_pkg::STATUS_W-1:0]   status,
	output logic [brf_pkg::BYTE_W-1:0]     read_byte,
	output logic [brf_pkg::OFFS_W-1:0]     found_offset,
	output logic [brf_pkg::FILL_W-1:0]     fill_level
);

	brf_pkg::ctl_cmd_t ctl;
	brf_pkg::dp_stat_t stat;

	brf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	brf_dp #(
		.DEPTH       (DEPTH),
		.PATTERN_MAX (PATTERN_MAX)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.command       (command),
		.data_byte     (data_byte),
		.pattern_bytes (pattern_bytes),
		.pattern_len   (pattern_len),
		.ctl           (ctl),
		.stat          (stat),
		.status        (status),
		.read_byte     (read_byte),
		.found_offset  (found_offset),
		.fill_level    (fill_level)
	);

	a_no_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> !(out_valid && out_stall))
		else $error("result loaded over a held result");

	a_pop_completes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command == brf_pkg::CMD_POP && !stat.empty)
		|=> (ctl.load_out && ctl.use_rdata))
		else $error("pop result not delivered on the next cycle");

	a_full_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command == brf_pkg::CMD_PUSH && stat.full)
		|-> (ctl.load_out && ctl.status == brf_pkg::ST_FULL && !ctl.push))
		else $error("push into full ring not dropped");

	a_scan_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan |-> in_stall)
		else $error("request accepted during scan");

endmodule

@@ tb/tb_byte_ring_fifo_with_search.sv @@
// Self-checking testbench for byte_ring_fifo_with_search: drives push, pop and find requests
// and checks every result against a ring model kept inside the bench.
// Depends on brf_pkg and the byte_ring_fifo_with_search RTL.
`timescale 1ns / 1ps

module tb_byte_ring_fifo_with_search;

	localparam int RING_SLOTS = brf_pkg::DEPTH_DEF;
	localparam int PAT_BYTES  = brf_pkg::PATTERN_MAX_DEF;
	localparam int CMD_W      = brf_pkg::CMD_W;
	localparam int BYTE_W     = brf_pkg::BYTE_W;
	localparam int PAT_W      = brf_pkg::PAT_W;
	localparam int LEN_W      = brf_pkg::LEN_W;
	localparam int STATUS_W   = brf_pkg::STATUS_W;
	localparam int OFFS_W     = brf_pkg::OFFS_W;
	localparam int FILL_W     = brf_pkg::FILL_W;

	typedef struct {
		brf_pkg::status_t   status;
		logic [BYTE_W-1:0]  read_byte;
		logic [OFFS_W-1:0]  offset;
		logic [FILL_W-1:0]  fill;
	} ring_outcome_t;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic [CMD_W-1:0]     command       = '0;
	logic [BYTE_W-1:0]    data_byte     = '0;
	logic [PAT_W-1:0]     pattern_bytes = '0;
	logic [LEN_W-1:0]     pattern_len   = '0;
	logic                 out_valid;
	logic                 out_stall     = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [BYTE_W-1:0]    read_byte;
	logic [OFFS_W-1:0]    found_offset;
	logic [FILL_W-1:0]    fill_level;

	logic [BYTE_W-1:0]    ring_mem [RING_SLOTS];
	int                   head_slot = 0;
	int                   tail_slot = 0;
	ring_outcome_t        pending_results [$];
	int                   mismatch_count = 0;
	bit                   idle_on = 1'b0;

	byte_ring_fifo_with_search dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.data_byte     (data_byte),
		.pattern_bytes (pattern_bytes),
		.pattern_len   (pattern_len),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.read_byte     (read_byte),
		.found_offset  (found_offset),
		.fill_level    (fill_level)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int held_count();
		return (tail_slot - head_slot + RING_SLOTS) % RING_SLOTS;
	endfunction

	function automatic logic [BYTE_W-1:0] byte_at(int offset);
		return ring_mem[(head_slot + offset) % RING_SLOTS];
	endfunction

	function automatic logic [BYTE_W-1:0] rand_byte();
		return BYTE_W'($urandom_range(255));
	endfunction

	// pattern of len bytes starting at offset, junk above the valid bytes
	function automatic logic [PAT_W-1:0] pattern_at(int offset, int len);
		logic [PAT_W-1:0] pat;
		pat = {$urandom, $urandom};
		for (int j = 0; j < len; j++)
			pat[8*j +: 8] = byte_at(offset + j);
		return pat;
	endfunction

	function automatic ring_outcome_t apply_ring_command(brf_pkg::cmd_t cmd,
			logic [BYTE_W-1:0] db, logic [PAT_W-1:0] pat, logic [LEN_W-1:0] len);
		ring_outcome_t r;
		int fill;
		bit hit;
		r.status = brf_pkg::ST_OK;
		r.read_byte = '0;
		r.offset = '0;
		fill = held_count();
		case (cmd)
			brf_pkg::CMD_PUSH: begin
				if (fill >= RING_SLOTS - 1) begin
					r.status = brf_pkg::ST_FULL;
				end else begin
					ring_mem[tail_slot] = db;
					tail_slot = (tail_slot + 1) % RING_SLOTS;
				end
			end
			brf_pkg::CMD_POP: begin
				if (fill == 0) begin
					r.status = brf_pkg::ST_EMPTY;
				end else begin
					r.read_byte = ring_mem[head_slot];
					head_slot = (head_slot + 1) % RING_SLOTS;
					if (head_slot == tail_slot) begin
						head_slot = 0;
						tail_slot = 0;
					end
				end
			end
			brf_pkg::CMD_FIND_BYTE: begin
				r.status = brf_pkg::ST_NOT_FOUND;
				for (int i = 0; i < fill; i++) begin
					if (byte_at(i) == db) begin
						r.status = brf_pkg::ST_OK;
						r.offset = OFFS_W'(i);
						break;
					end
				end
			end
			default: begin
				r.status = brf_pkg::ST_NOT_FOUND;
				if (len != 0 && int'(len) <= PAT_BYTES && int'(len) <= fill) begin
					for (int i = 0; i + int'(len) <= fill; i++) begin
						hit = 1'b1;
						for (int j = 0; j < int'(len); j++)
							if (byte_at(i + j) != pat[8*j +: 8])
								hit = 1'b0;
						if (hit) begin
							r.status = brf_pkg::ST_OK;
							r.offset = OFFS_W'(i);
							break;
						end
					end
				end
			end
		endcase
		r.fill = FILL_W'(held_count());
		return r;
	endfunction

	task automatic send_request(brf_pkg::cmd_t cmd, logic [BYTE_W-1:0] db,
			logic [PAT_W-1:0] pat, logic [LEN_W-1:0] len);
		ring_outcome_t r;
		while (idle_on && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		data_byte     <= db;
		pattern_bytes <= pat;
		pattern_len   <= len;
		r = apply_ring_command(cmd, db, pat, len);
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		pending_results.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_result();
		ring_outcome_t want;
		if (pending_results.size() == 0) begin
			$error("unexpected result: status %0d, fill_level %0d", status, fill_level);
			mismatch_count++;
		end else begin
			want = pending_results.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				mismatch_count++;
			end
			if (read_byte !== want.read_byte) begin
				$error("read_byte: expected %0h, got %0h", want.read_byte, read_byte);
				mismatch_count++;
			end
			if (found_offset !== want.offset) begin
				$error("found_offset: expected %0d, got %0d", want.offset, found_offset);
				mismatch_count++;
			end
			if (fill_level !== want.fill) begin
				$error("fill_level: expected %0d, got %0d", want.fill, fill_level);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall)
			check_result();
		out_stall <= idle_on && ($urandom_range(99) < 28);
	end

	task automatic test_empty_ring();
		send_request(brf_pkg::CMD_POP, 8'hFF, '1, 4'hF);
		send_request(brf_pkg::CMD_FIND_BYTE, 8'h00, '0, 4'd0);
		send_request(brf_pkg::CMD_FIND_PAT, 8'h00, '0, 4'd1);
		send_request(brf_pkg::CMD_FIND_PAT, 8'hFF, '1, 4'd0);
	endtask

	task automatic test_basic_commands();
		send_request(brf_pkg::CMD_PUSH, 8'h00, '1, 4'hF);
		send_request(brf_pkg::CMD_PUSH, 8'hFF, '0, 4'd0);
		send_request(brf_pkg::CMD_PUSH, 8'hA5, '1, 4'd8);
		send_request(brf_pkg::CMD_PUSH, 8'h5A, '0, 4'd3);
		send_request(brf_pkg::CMD_PUSH, 8'hFF, '1, 4'd1);
		send_request(brf_pkg::CMD_FIND_BYTE, 8'hFF, '1, 4'hF);
		send_request(brf_pkg::CMD_FIND_BYTE, 8'h5A, '0, 4'd0);
		send_request(brf_pkg::CMD_FIND_BYTE, 8'h77, '1, 4'd2);
		send_request(brf_pkg::CMD_FIND_PAT, 8'h00, {48'hFFFF_FFFF_FFFF, 8'hA5, 8'hFF}, 4'd2);
		send_request(brf_pkg::CMD_FIND_PAT, 8'hFF, pattern_at(0, 5), 4'd5);
		send_request(brf_pkg::CMD_FIND_PAT, 8'h00, pattern_at(0, 5), 4'd6);
		send_request(brf_pkg::CMD_FIND_PAT, 8'h00, pattern_at(0, 5), 4'd9);
		send_request(brf_pkg::CMD_FIND_PAT, 8'h00, pattern_at(0, 5), 4'hF);
		send_request(brf_pkg::CMD_FIND_PAT, 8'h00, {56'h0, 8'hFF}, 4'd1);
		send_request(brf_pkg::CMD_FIND_PAT, 8'h00, {48'h0, 8'h00, 8'h5A}, 4'd2);
		repeat (6) send_request(brf_pkg::CMD_POP, rand_byte(), {$urandom, $urandom},
			4'($urandom));
		send_request(brf_pkg::CMD_PUSH, 8'h3C, '0, 4'd0);
		send_request(brf_pkg::CMD_FIND_BYTE, 8'h3C, '0, 4'd0);
	endtask

	task automatic test_full_ring();
		int held;
		// mark the last three bytes so finds have to scan the whole ring
		while (held_count() < RING_SLOTS - 1) begin
			held = held_count();
			if (held >= RING_SLOTS - 4)
				send_request(brf_pkg::CMD_PUSH,
					BYTE_W'(8'hFC + held - (RING_SLOTS - 4)), '0, 4'd0);
			else
				send_request(brf_pkg::CMD_PUSH, BYTE_W'($urandom_range(8'hEF)), '0, 4'd0);
		end
		send_request(brf_pkg::CMD_PUSH, 8'h00, '0, 4'd0);
		send_request(brf_pkg::CMD_PUSH, 8'hFF, '1, 4'hF);
		send_request(brf_pkg::CMD_FIND_BYTE, 8'hFE, '0, 4'd0);
		send_request(brf_pkg::CMD_FIND_BYTE, 8'hFF, '0, 4'd0);
		send_request(brf_pkg::CMD_FIND_PAT, 8'h00, pattern_at(RING_SLOTS - 4, 3), 4'd3);
		send_request(brf_pkg::CMD_FIND_PAT, 8'h00, pattern_at(RING_SLOTS - 9, 8), 4'd8);
		repeat (5) send_request(brf_pkg::CMD_POP, rand_byte(), '0, 4'd0);
		repeat (5) send_request(brf_pkg::CMD_PUSH, BYTE_W'($urandom_range(8'hEF)), '0, 4'd0);
		send_request(brf_pkg::CMD_PUSH, 8'hFF, '0, 4'd0);
		send_request(brf_pkg::CMD_FIND_BYTE, 8'hFE, '0, 4'd0);
		send_request(brf_pkg::CMD_FIND_PAT, 8'h00, pattern_at(RING_SLOTS - 10, 8), 4'd8);
		send_request(brf_pkg::CMD_FIND_PAT, 8'h00, pattern_at(RING_SLOTS - 3, 2), 4'd2);
		while (held_count() > 0)
			send_request(brf_pkg::CMD_POP, rand_byte(), '0, 4'd0);
		send_request(brf_pkg::CMD_POP, 8'h00, '0, 4'd0);
	endtask

	task automatic test_random_traffic(int count);
		int fill;
		int pick;
		int len;
		int off;
		int flip;
		logic [BYTE_W-1:0] db;
		logic [PAT_W-1:0] pat;
		repeat (count) begin
			fill = held_count();
			pick = $urandom_range(99);
			db = $urandom_range(1) ? rand_byte() : BYTE_W'(8'h41 + $urandom_range(3));
			pat = {$urandom, $urandom};
			len = $urandom_range(15);
			if (pick < (fill < 120 ? 40 : 15)) begin
				send_request(brf_pkg::CMD_PUSH, db, pat, LEN_W'(len));
			end else if (pick < 65) begin
				send_request(brf_pkg::CMD_POP, db, pat, LEN_W'(len));
			end else if (pick < 82) begin
				if (fill > 0 && $urandom_range(9) < 6)
					db = byte_at($urandom_range(fill - 1));
				send_request(brf_pkg::CMD_FIND_BYTE, db, pat, LEN_W'(len));
			end else begin
				if (fill > 0 && $urandom_range(9) < 7) begin
					len = $urandom_range(1, fill < PAT_BYTES ? fill : PAT_BYTES);
					off = $urandom_range(fill - len);
					pat = pattern_at(off, len);
					if ($urandom_range(9) == 0) begin
						flip = 8 * $urandom_range(len - 1) + $urandom_range(7);
						pat[flip] = ~pat[flip];
					end
				end
				send_request(brf_pkg::CMD_FIND_PAT, db, pat, LEN_W'(len));
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		test_empty_ring();
		test_basic_commands();
		test_full_ring();
		idle_on = 1'b0;
		test_random_traffic(150);
		idle_on = 1'b1;
		test_random_traffic(200);
		in_valid <= 1'b0;
		wait_drained();
		test_random_traffic(200);
		in_valid <= 1'b0;
		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/brf_pkg.sv
rtl/brf_ram.sv
rtl/brf_ctrl.sv
rtl/brf_dp.sv
rtl/byte_ring_fifo_with_search.sv
tb/tb_byte_ring_fifo_with_search.sv
